// ===== design/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants for the PLL divider search
// Limits of the divider ranges and the command/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int unsigned M_LO = 2;
    localparam int unsigned M_HI = 63;
    localparam int unsigned N_HI = 432;
    localparam int unsigned P_HI = 3;
    localparam int unsigned Q_LO = 2;
    localparam int unsigned Q_HI = 15;

    localparam logic [8:0] N_MIN_F2 = 9'd64;
    localparam logic [8:0] N_MIN_F4 = 9'd192;

    localparam logic [27:0] HZ_1M    = 28'd1000000;
    localparam logic [27:0] HZ_2M    = 28'd2000000;
    localparam logic [27:0] VCO_LO_F2 = 28'd64000000;
    localparam logic [27:0] VCO_LO_F4 = 28'd192000000;
    localparam logic [28:0] VCO_MAX  = 29'd432000000;
    localparam logic [27:0] SYS_F2   = 28'd120000000;
    localparam logic [27:0] SYS_F4   = 28'd168000000;
    localparam logic [25:0] USB_HZ   = 26'd48000000;
    localparam logic [16:0] USB_TOL  = 17'd120000;

    // request payload
    typedef struct packed {
        logic [26:0] source_hz;
        logic [27:0] sys_min_hz;
        logic [27:0] sys_max_hz;
        logic        need_usb_exact;
        logic        family;
    } t_req;

    // result payload
    typedef struct packed {
        logic       found;
        logic [5:0] div_m;
        logic [8:0] mul_n;
        logic [1:0] p_field;
        logic [3:0] div_q;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture request, reset best
        logic step;   // evaluate current candidate and advance
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;   // last candidate evaluated or M loop ended
    } t_sts;

endpackage

// ===== design/pds_if.sv =====
// ----------------------------------------------------------------------------
// pds_if: valid/ready channel
// Carries one payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface pds_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pll_divider_search.sv =====
// ----------------------------------------------------------------------------
// pll_divider_search: exhaustive PLL divider search
// Finds the divider set (M, N, P, Q) that meets the clock limits.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (source clock, system clock limits, USB flag,
//   family); o_res returns exactly one result item per request.
//   Requests are handled one at a time: i_req.ready is high only while idle.
//   The search tests one candidate per cycle in M, N, P, Q order. An M whose
//   VCO input is out of range is left after its first candidate; an in-range
//   M runs through every N from nmin to 432, every P and every Q. The search
//   stops after the first M that yields a valid set, or after M = 63.
//   The result is presented once the sequencer has registered the done flag, and
//   held on o_res until taken; a stalled receiver simply holds the block.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
//   any search in progress.
// ----------------------------------------------------------------------------
module pll_divider_search (
    input  logic i_clk,
    input  logic i_rst_n,
    pds_if.sink   i_req,
    pds_if.source o_res
);

    pds_pkg::t_cmd cmd;
    pds_pkg::t_sts sts;

    pds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pds_dp u_dp (
        .i_clk (i_clk),
        .i_req (i_req.data),
        .i_cmd (cmd),
        .o_sts (sts),
        .o_res (o_res.data)
    );

`ifndef ASSERT_OFF
    // never accept while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_res.valid))
        else $error("request accepted while result pending");
    // a load and a step never coincide
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.step))
        else $error("load and step together");
    // a found result has M in range
    a_found_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.found) |-> (o_res.data.div_m >= 6'd2))
        else $error("found result with bad M");
`endif

endmodule

// ===== design/pds_ctrl.sv =====
// ----------------------------------------------------------------------------
// pds_ctrl: search sequencer
// Accepts a request, steps the datapath until done, then presents the result.
// ----------------------------------------------------------------------------
module pds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pds_pkg::t_cmd o_cmd,
    input  pds_pkg::t_sts i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RUN;
            S_RUN:  if (i_sts.done) n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.step  = (r_state == S_RUN) && !i_sts.done;

endmodule

// ===== design/pds_dp.sv =====
// ----------------------------------------------------------------------------
// pds_dp: candidate datapath
// Holds the request, the (M, N, P, Q) counters and the best set so far;
// tests one candidate a cycle while stepped, with exact integer products.
// ----------------------------------------------------------------------------
module pds_dp (
    input  logic          i_clk,
    input  pds_pkg::t_req i_req,
    input  pds_pkg::t_cmd i_cmd,
    output pds_pkg::t_sts o_sts,
    output pds_pkg::t_res o_res
);

    pds_pkg::t_req r_req;
    logic [5:0] r_m;
    logic [8:0] r_n;
    logic [1:0] r_p;
    logic [3:0] r_q;
    logic       r_have;
    logic       r_mdone;    // search done: a set was found or the last M ended
    logic [5:0] r_bm;
    logic [8:0] r_bn;
    logic [1:0] r_bp;
    logic [3:0] r_bq;

    logic [8:0]  nmin;
    logic [27:0] vco_lo, sys_hi;
    logic [35:0] f;
    logic [8:0]  sd;        // M * 2 * (P + 1), up to 504
    logic [9:0]  ud;
    logic [33:0] lim_m1, lim_m2;
    logic [34:0] vco_lo_m, vco_hi_m;
    logic [36:0] sys_hi_sd, smin_sd, smax_sd;
    logic [35:0] target, tol;
    logic        ok_in, ok_vco, ok_sys, ok_usb, better;
    logic        last_q, last_p, last_n, last_m;

    assign nmin   = r_req.family ? pds_pkg::N_MIN_F4 : pds_pkg::N_MIN_F2;
    assign vco_lo = r_req.family ? pds_pkg::VCO_LO_F4 : pds_pkg::VCO_LO_F2;
    assign sys_hi = r_req.family ? pds_pkg::SYS_F4 : pds_pkg::SYS_F2;

    // candidate tests
    always_comb begin
        f         = 36'(r_req.source_hz) * 36'(r_n);
        sd        = 9'({r_m, 1'b0}) * 9'({1'b0, r_p} + 3'd1);
        ud        = 10'(r_m) * 10'(r_q);
        lim_m1    = 34'(pds_pkg::HZ_1M) * 34'(r_m);
        lim_m2    = 34'(pds_pkg::HZ_2M) * 34'(r_m);
        vco_lo_m  = 35'(vco_lo) * 35'(r_m);
        vco_hi_m  = 35'(pds_pkg::VCO_MAX) * 35'(r_m);
        sys_hi_sd = 37'(sys_hi) * 37'(sd);
        smin_sd   = 37'(r_req.sys_min_hz) * 37'(sd);
        smax_sd   = 37'(r_req.sys_max_hz) * 37'(sd);
        target    = 36'(pds_pkg::USB_HZ) * 36'(ud);
        tol       = 36'(pds_pkg::USB_TOL) * 36'(ud);
        ok_in  = !(34'(r_req.source_hz) < lim_m1) && !(34'(r_req.source_hz) > lim_m2);
        ok_vco = !(f < 36'(vco_lo_m)) && !(f > 36'(vco_hi_m));
        ok_sys = !(37'(f) > sys_hi_sd)
               && !(r_req.sys_min_hz != '0 && 37'(f) < smin_sd)
               && !(r_req.sys_max_hz != '0 && 37'(f) > smax_sd);
        ok_usb = !(f > target) && !(r_req.need_usb_exact && (target - f) > tol);
        better = !r_have
               || (12'(r_n) * 12'({1'b0, r_bp} + 3'd1) > 12'(r_bn) * 12'({1'b0, r_p} + 3'd1));
        last_q = (r_q == 4'(pds_pkg::Q_HI));
        last_p = (r_p == 2'(pds_pkg::P_HI));
        last_n = (r_n == 9'(pds_pkg::N_HI));
        last_m = (r_m == 6'(pds_pkg::M_HI));
    end

    assign o_sts.done = r_mdone;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_m     <= 6'(pds_pkg::M_LO);
            r_n     <= i_req.family ? pds_pkg::N_MIN_F4 : pds_pkg::N_MIN_F2;
            r_p     <= '0;
            r_q     <= 4'(pds_pkg::Q_LO);
            r_have  <= 1'b0;
            r_mdone <= 1'b0;
            r_bm <= '0; r_bn <= '0; r_bp <= '0; r_bq <= '0;
        end else if (i_cmd.step) begin
            // keep a better set
            if (ok_in && ok_vco && ok_sys && ok_usb && better) begin
                r_have <= 1'b1;
                r_bm <= r_m; r_bn <= r_n; r_bp <= r_p; r_bq <= r_q;
            end
            // advance; a failing VCO input test skips the whole M
            if (!ok_in || (last_q && last_p && last_n)) begin
                r_q <= 4'(pds_pkg::Q_LO);
                r_p <= '0;
                r_n <= nmin;
                r_m <= r_m + 6'd1;
                if (last_m || r_have || (ok_in && ok_vco && ok_sys && ok_usb))
                    r_mdone <= 1'b1;
            end else if (last_q && last_p) begin
                r_q <= 4'(pds_pkg::Q_LO);
                r_p <= '0;
                r_n <= r_n + 9'd1;
            end else if (last_q) begin
                r_q <= 4'(pds_pkg::Q_LO);
                r_p <= r_p + 2'd1;
            end else begin
                r_q <= r_q + 4'd1;
            end
        end
    end

    assign o_res.found   = r_have;
    assign o_res.div_m   = r_bm;
    assign o_res.mul_n   = r_bn;
    assign o_res.p_field = r_bp;
    assign o_res.div_q   = r_bq;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for pll_divider_search
// Sends directed and random divider search requests through the request
// channel and checks every result against a local exhaustive search. Both
// channels idle at random. The result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int          N_RANDOM  = 80;
    localparam longint      CYC_LIMIT = 400000000;
    localparam logic [26:0] SRC_MAX   = 27'd100000000;
    localparam logic [27:0] LIM_MAX   = 28'd168000000;

    // scoreboard: local divider search and store of expected results
    class divider_scoreboard;
        pds_pkg::t_res pending_res[$];
        int   n_errors;
        int   n_checked;
        int   n_found;

        function automatic pds_pkg::t_res search_dividers(pds_pkg::t_req r);
            longint unsigned src, smin, smax, nmin, vco_lo, sys_hi;
            longint unsigned f, sd, ud, tgt, m, n, p, q;
            longint unsigned bm, bn, bp, bq;
            bit have;
            pds_pkg::t_res res;
            src    = 64'(r.source_hz);
            smin   = 64'(r.sys_min_hz);
            smax   = 64'(r.sys_max_hz);
            nmin   = r.family ? 64'(pds_pkg::N_MIN_F4) : 64'(pds_pkg::N_MIN_F2);
            vco_lo = r.family ? 64'(pds_pkg::VCO_LO_F4) : 64'(pds_pkg::VCO_LO_F2);
            sys_hi = r.family ? 64'(pds_pkg::SYS_F4) : 64'(pds_pkg::SYS_F2);
            have = 0;
            bm = 0; bn = 0; bp = 0; bq = 0;
            for (m = pds_pkg::M_LO; m <= pds_pkg::M_HI && !have; m++) begin
                if (src < 64'(pds_pkg::HZ_1M) * m || src > 64'(pds_pkg::HZ_2M) * m)
                    continue;
                for (n = nmin; n <= pds_pkg::N_HI; n++) begin
                    f = src * n;  // VCO frequency scaled by m
                    if (f < vco_lo * m || f > 64'(pds_pkg::VCO_MAX) * m) continue;
                    for (p = 0; p <= pds_pkg::P_HI; p++) begin
                        sd = m * 2 * (p + 1);
                        if (f > sys_hi * sd) continue;
                        if (smin != 0 && f < smin * sd) continue;
                        if (smax != 0 && f > smax * sd) continue;
                        for (q = pds_pkg::Q_LO; q <= pds_pkg::Q_HI; q++) begin
                            ud  = m * q;
                            tgt = 64'(pds_pkg::USB_HZ) * ud;
                            if (f > tgt) continue;
                            if (r.need_usb_exact && tgt - f > 64'(pds_pkg::USB_TOL) * ud)
                                continue;
                            // same m: higher system clock wins, first kept on tie
                            if (!have || n * (bp + 1) > bn * (p + 1)) begin
                                have = 1;
                                bm = m; bn = n; bp = p; bq = q;
                            end
                        end
                    end
                end
            end
            res.found   = have;
            res.div_m   = bm[5:0];
            res.mul_n   = bn[8:0];
            res.p_field = bp[1:0];
            res.div_q   = bq[3:0];
            return res;
        endfunction

        function void note_request(pds_pkg::t_req r);
            pending_res.push_back(search_dividers(r));
        endfunction

        function void check_result(pds_pkg::t_res got);
            pds_pkg::t_res exp_res;
            if (pending_res.size() == 0) begin
                $error("result with no request pending");
                n_errors++;
                return;
            end
            exp_res = pending_res.pop_front();
            n_checked++;
            if (exp_res.found) n_found++;
            if (got.found !== exp_res.found) begin
                $error("found: expected %0d, got %0d", exp_res.found, got.found);
                n_errors++;
            end
            if (got.div_m !== exp_res.div_m) begin
                $error("div_m: expected %0d, got %0d", exp_res.div_m, got.div_m);
                n_errors++;
            end
            if (got.mul_n !== exp_res.mul_n) begin
                $error("mul_n: expected %0d, got %0d", exp_res.mul_n, got.mul_n);
                n_errors++;
            end
            if (got.p_field !== exp_res.p_field) begin
                $error("p_field: expected %0d, got %0d", exp_res.p_field, got.p_field);
                n_errors++;
            end
            if (got.div_q !== exp_res.div_q) begin
                $error("div_q: expected %0d, got %0d", exp_res.div_q, got.div_q);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    longint cyc_count;
    int     n_accepted;
    int     stall_left;
    bit     long_stall_done;

    pds_if #(.T(pds_pkg::t_req)) req_if ();
    pds_if #(.T(pds_pkg::t_res)) res_if ();

    divider_scoreboard sb;

    pll_divider_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic pds_pkg::t_req make_req(logic [26:0] src, logic [27:0] smin,
                                               logic [27:0] smax, logic usb, logic fam);
        pds_pkg::t_req r;
        r.source_hz      = src;
        r.sys_min_hz     = smin;
        r.sys_max_hz     = smax;
        r.need_usb_exact = usb;
        r.family         = fam;
        return r;
    endfunction

    // random request: mostly ordinary set-ups, some noise
    function automatic pds_pkg::t_req rand_req();
        pds_pkg::t_req r;
        int   kind;
        kind = $urandom_range(0, 99);
        r.need_usb_exact = 1'($urandom_range(0, 1));
        r.family         = 1'($urandom_range(0, 1));
        if (kind < 45) begin
            // whole-MHz source, no or broad limits
            r.source_hz  = 27'(longint'($urandom_range(1, 100)) * 1000000);
            r.sys_min_hz = ($urandom_range(0, 1)) ? 28'd0 : 28'($urandom_range(0, 48000000));
            r.sys_max_hz = ($urandom_range(0, 1)) ? 28'd0
                                                  : 28'($urandom_range(100000000, LIM_MAX));
        end else if (kind < 80) begin
            // arbitrary source, no limits
            r.source_hz  = 27'($urandom_range(0, SRC_MAX));
            r.sys_min_hz = '0;
            r.sys_max_hz = '0;
        end else begin
            // small source, arbitrary limits; keeps failing searches short
            r.source_hz  = 27'($urandom_range(0, 8000000));
            r.sys_min_hz = 28'($urandom_range(0, LIM_MAX));
            r.sys_max_hz = 28'($urandom_range(0, LIM_MAX));
            if ($urandom_range(0, 3) == 0) r.sys_min_hz = '0;
        end
        return r;
    endfunction

    // drive one request, keeping valid high across back-to-back items
    task automatic send_request(pds_pkg::t_req r);
        int  gap;
        bit  rdy;
        gap = idle_len();
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        forever begin
            #1;
            rdy = req_if.ready;
            @(posedge i_clk);
            if (rdy) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.data);
                n_accepted++;
            end
            if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
        end
    end

    // result side: random idling, one long hold-off
    always @(negedge i_clk) begin
        if (!long_stall_done && n_accepted == 6) begin
            long_stall_done = 1;
            stall_left = 50000;
        end
        if (stall_left > 0) begin
            res_if.ready = 1'b0;
            stall_left--;
        end else begin
            res_if.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cyc_count++;
        if (cyc_count >= CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        pds_pkg::t_req directed[$];
        sb = new();
        cyc_count       = 0;
        n_accepted      = 0;
        stall_left      = 0;
        long_stall_done = 0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero, tiny and largest sources, both families, USB modes
        directed.push_back(make_req(27'd0, 28'd0, 28'd0, 1'b0, 1'b0));
        directed.push_back(make_req(27'd1, 28'd0, 28'd0, 1'b0, 1'b1));
        directed.push_back(make_req(27'd1999999, 28'd0, 28'd0, 1'b1, 1'b0));
        directed.push_back(make_req(27'd2000000, 28'd0, 28'd0, 1'b1, 1'b1));
        directed.push_back(make_req(27'd8000000, 28'd0, 28'd0, 1'b0, 1'b0));
        directed.push_back(make_req(27'd8000000, 28'd0, 28'd0, 1'b1, 1'b0));
        directed.push_back(make_req(27'd8000000, 28'd0, 28'd0, 1'b1, 1'b1));
        directed.push_back(make_req(27'd25000000, 28'd0, 28'd0, 1'b0, 1'b1));
        directed.push_back(make_req(27'd25000000, 28'd0, LIM_MAX, 1'b1, 1'b1));
        directed.push_back(make_req(SRC_MAX, 28'd0, 28'd0, 1'b0, 1'b0));
        directed.push_back(make_req(SRC_MAX, LIM_MAX, LIM_MAX, 1'b0, 1'b1));
        // minimum above or equal to maximum
        directed.push_back(make_req(27'd12000000, 28'd100000000, 28'd50000000, 1'b0, 1'b0));
        directed.push_back(make_req(27'd16000000, 28'd48000000, 28'd48000000, 1'b1, 1'b0));
        // limits beyond the family bound
        directed.push_back(make_req(27'd4000000, 28'd0, LIM_MAX, 1'b0, 1'b0));
        directed.push_back(make_req(27'd3000000, LIM_MAX, 28'd0, 1'b0, 1'b0));
        directed.push_back(make_req(27'd26000000, 28'd30000000, 28'd72000000, 1'b1, 1'b1));
        directed.push_back(make_req(27'd12288000, 28'd0, 28'd0, 1'b1, 1'b0));
        directed.push_back(make_req(27'd5000000, 28'd60000000, 28'd0, 1'b0, 1'b1));

        foreach (directed[i]) send_request(directed[i]);
        repeat (N_RANDOM) send_request(rand_req());
        req_if.valid = 1'b0;

        wait (n_accepted == directed.size() + N_RANDOM && sb.pending_res.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results (%0d with a divider set found), %0d requests sent.",
                 sb.n_checked, sb.n_found, n_accepted);
        $display("Covered both families, USB exact mode, limits and a long result stall.");
        if (sb.n_errors == 0 && sb.pending_res.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
